/* hdl/bfha_pkg.sv */
package bfha_pkg;

   localparam int HEAP_BYTES    = 4096;
   localparam int GRANULE_BYTES = 8;
   localparam int HEAP_GRANULES = HEAP_BYTES / GRANULE_BYTES;
   localparam int GRAN_W        = $clog2(HEAP_GRANULES);
   localparam int IDX_W         = GRAN_W + 1;
   localparam int GSHIFT        = $clog2(GRANULE_BYTES);
   localparam int OFF_W         = 12;
   localparam int REQ_W         = 16;
   localparam int ROUND_W       = REQ_W + 1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_LARGE    = 3'd2,
      ST_NOFIT    = 3'd3,
      ST_OUTSIDE  = 3'd4,
      ST_FREED    = 3'd5,
      ST_NOTFOUND = 3'd6
   } status_type;

   typedef struct packed {
      logic              used;
      logic [GRAN_W-1:0] size;
   } header_type;

   localparam header_type RESET_HEADER = '{used: 1'b0, size: GRAN_W'(HEAP_GRANULES - 1)};

   // sequencer to datapath
   typedef struct packed {
      logic       load;
      logic       walk;
      logic       read_nx;
      logic       read_pv;
      logic       write_free;
      logic       write_alloc;
      logic       write_trailer;
      logic       set_status;
      status_type code;
      logic       emit;
   } cmd_type;

   // datapath to sequencer
   typedef struct packed {
      logic is_free;
      logic zero;
      logic oversize;
      logic outside;
      logic walk_end;
      logic found;
      logic exact;
      logic match;
      logic hdr_used;
      logic trailer;
   } stat_type;

endpackage

/* hdl/bfha_req_if.sv */
interface bfha_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [bfha_pkg::REQ_W-1:0]    request_bytes;
   logic [bfha_pkg::REQ_W-1:0]    free_offset;

   modport source(output valid, action, request_bytes, free_offset, input ready);
   modport sink(input valid, action, request_bytes, free_offset, output ready);
endinterface

/* hdl/bfha_rsp_if.sv */
interface bfha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfha_pkg::OFF_W-1:0]    payload_offset;
   bfha_pkg::status_type          status;

   modport source(output valid, payload_offset, status, input ready);
   modport sink(input valid, payload_offset, status, output ready);
endinterface

/* hdl/bfha_ctrl.sv */
module bfha_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  bfha_pkg::stat_type stat,
   output bfha_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_CHECK    = 9'b000000010,
      S_WALK     = 9'b000000100,
      S_FREE_CHK = 9'b000001000,
      S_FREE_NX  = 9'b000010000,
      S_FREE_PV  = 9'b000100000,
      S_ALLOC_WR = 9'b001000000,
      S_ALLOC_TR = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.zero) begin
               cmd.set_status = 1'b1;
               cmd.code       = bfha_pkg::ST_ZERO;
               state_in       = S_DONE;
            end else if (stat.oversize) begin
               cmd.set_status = 1'b1;
               cmd.code       = bfha_pkg::ST_LARGE;
               state_in       = S_DONE;
            end else if (stat.outside) begin
               cmd.set_status = 1'b1;
               cmd.code       = bfha_pkg::ST_OUTSIDE;
               state_in       = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_end) begin
               if (stat.is_free) begin
                  cmd.set_status = 1'b1;
                  cmd.code       = bfha_pkg::ST_NOTFOUND;
                  state_in       = S_DONE;
               end else if (stat.found) begin
                  state_in = S_ALLOC_WR;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.code       = bfha_pkg::ST_NOFIT;
                  state_in       = S_DONE;
               end
            end else if (!stat.is_free && stat.exact) begin
               state_in = S_ALLOC_WR;
            end else if (stat.is_free && stat.match) begin
               state_in = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            if (!stat.hdr_used) begin
               cmd.set_status = 1'b1;
               cmd.code       = bfha_pkg::ST_FREED;
               state_in       = S_DONE;
            end else begin
               cmd.read_nx = 1'b1;
               state_in    = S_FREE_NX;
            end
         end
         S_FREE_NX: begin
            cmd.read_pv = 1'b1;
            state_in    = S_FREE_PV;
         end
         S_FREE_PV: begin
            cmd.write_free = 1'b1;
            cmd.set_status = 1'b1;
            cmd.code       = bfha_pkg::ST_OK;
            state_in       = S_DONE;
         end
         S_ALLOC_WR: begin
            cmd.write_alloc = 1'b1;
            if (stat.trailer) begin
               state_in = S_ALLOC_TR;
            end else begin
               cmd.set_status = 1'b1;
               cmd.code       = bfha_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_ALLOC_TR: begin
            cmd.write_trailer = 1'b1;
            cmd.set_status    = 1'b1;
            cmd.code          = bfha_pkg::ST_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/bfha_datapath.sv */
module bfha_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_action,
   input  logic [bfha_pkg::REQ_W-1:0]   req_bytes,
   input  logic [bfha_pkg::REQ_W-1:0]   req_offset,
   input  bfha_pkg::cmd_type            cmd,
   output bfha_pkg::stat_type           stat,
   output logic [bfha_pkg::OFF_W-1:0]   rsp_payload_offset,
   output bfha_pkg::status_type         rsp_status
);

   localparam int GW = bfha_pkg::GRAN_W;
   localparam int IW = bfha_pkg::IDX_W;
   localparam int RW = bfha_pkg::ROUND_W;
   localparam int QW = bfha_pkg::REQ_W - bfha_pkg::GSHIFT;

   bfha_pkg::header_type mem [bfha_pkg::HEAP_GRANULES];

   bfha_pkg::header_type rd_ff;
   logic                 rd_zero_ff;
   logic                 e0_ff;
   bfha_pkg::header_type hdr;

   logic                          action_ff;
   logic [GW-1:0]                 want_ff;
   logic                          zero_ff, oversize_ff, outside_ff;
   logic [bfha_pkg::REQ_W-1:0]    off_ff;
   logic [IW-1:0]                 cur_ff;
   logic [GW-1:0]                 prev_ff;
   logic [GW-1:0]                 best_idx_ff;
   logic [IW-1:0]                 best_gran_ff;
   logic                          found_ff;
   logic [IW-1:0]                 sacc_ff;
   logic                          nx_ok_ff;
   bfha_pkg::status_type          res_code_ff;
   logic [bfha_pkg::OFF_W-1:0]    res_off_ff;
   logic [bfha_pkg::OFF_W-1:0]    rsp_off_ff;
   bfha_pkg::status_type          rsp_code_ff;

   logic [RW-1:0]                 want;
   logic [IW-1:0]                 cur_next;
   logic                          walk_end, exact, better, match, advance;
   logic                          prev_free;
   logic [bfha_pkg::OFF_W-1:0]    alloc_off;
   logic                          rd_en, wr_en;
   logic [GW-1:0]                 rd_addr, wr_addr;
   bfha_pkg::header_type          wr_data;

   // entry 0 reads as the whole free heap until first written
   assign hdr = (rd_zero_ff && !e0_ff) ? bfha_pkg::RESET_HEADER : rd_ff;

   assign want = (RW'(req_bytes) + RW'(bfha_pkg::GRANULE_BYTES - 1)) >> bfha_pkg::GSHIFT;

   assign cur_next = cur_ff + IW'(1) + IW'(hdr.size);
   assign walk_end = cur_ff >= IW'(bfha_pkg::HEAP_GRANULES - 1);
   assign exact    = !hdr.used && (hdr.size == want_ff);
   assign better   = !hdr.used && (hdr.size > want_ff) && (IW'(hdr.size) < best_gran_ff);
   assign match    = (off_ff[bfha_pkg::GSHIFT-1:0] == '0) &&
                     (off_ff[bfha_pkg::REQ_W-1:bfha_pkg::GSHIFT] == QW'(cur_ff + IW'(1)));
   assign advance  = action_ff ? !match : !exact;
   assign prev_free = (cur_ff != '0) && !hdr.used;
   assign alloc_off = {best_idx_ff + GW'(1), {bfha_pkg::GSHIFT{1'b0}}};

   assign stat.is_free  = action_ff;
   assign stat.zero     = !action_ff && zero_ff;
   assign stat.oversize = !action_ff && oversize_ff;
   assign stat.outside  = action_ff && outside_ff;
   assign stat.walk_end = walk_end;
   assign stat.found    = found_ff;
   assign stat.exact    = exact;
   assign stat.match    = match;
   assign stat.hdr_used = hdr.used;
   assign stat.trailer  = best_gran_ff > (IW'(want_ff) + IW'(1));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.load) begin
         rd_en = 1'b1;
      end else if (cmd.walk && !walk_end && advance) begin
         rd_en   = 1'b1;
         rd_addr = cur_next[GW-1:0];
      end else if (cmd.read_nx) begin
         rd_en   = 1'b1;
         rd_addr = cur_next[GW-1:0];
      end else if (cmd.read_pv) begin
         rd_en   = 1'b1;
         rd_addr = prev_ff;
      end
      if (cmd.write_free) begin
         wr_en = 1'b1;
         if (prev_free) begin
            wr_addr = prev_ff;
            wr_data = '{used: 1'b0, size: hdr.size + sacc_ff[GW-1:0] + GW'(1)};
         end else begin
            wr_addr = cur_ff[GW-1:0];
            wr_data = '{used: 1'b0, size: sacc_ff[GW-1:0]};
         end
      end else if (cmd.write_alloc) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         // a single granule left over is absorbed
         if (best_gran_ff == IW'(want_ff) + IW'(1)) begin
            wr_data = '{used: 1'b1, size: best_gran_ff[GW-1:0]};
         end else begin
            wr_data = '{used: 1'b1, size: want_ff};
         end
      end else if (cmd.write_trailer) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff + GW'(1) + want_ff;
         wr_data = '{used: 1'b0, size: best_gran_ff[GW-1:0] - want_ff - GW'(1)};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff      <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff <= 1'b0;
      end else if (wr_en && wr_addr == '0) begin
         e0_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         want_ff      <= want[GW-1:0];
         zero_ff      <= (req_bytes == '0);
         oversize_ff  <= want > RW'(bfha_pkg::HEAP_GRANULES - 1);
         outside_ff   <= RW'(req_offset) > RW'(bfha_pkg::HEAP_BYTES);
         off_ff       <= req_offset;
         cur_ff       <= '0;
         prev_ff      <= '0;
         best_idx_ff  <= '0;
         best_gran_ff <= IW'(bfha_pkg::HEAP_GRANULES);
         found_ff     <= 1'b0;
      end else if (cmd.walk && !walk_end) begin
         if (!action_ff) begin
            if (exact || better) begin
               best_idx_ff  <= cur_ff[GW-1:0];
               best_gran_ff <= IW'(hdr.size);
               found_ff     <= 1'b1;
            end
            if (!exact) begin
               cur_ff <= cur_next;
            end
         end else if (!match) begin
            prev_ff <= cur_ff[GW-1:0];
            cur_ff  <= cur_next;
         end
      end
      if (cmd.read_nx) begin
         sacc_ff  <= IW'(hdr.size);
         nx_ok_ff <= cur_next < IW'(bfha_pkg::HEAP_GRANULES);
      end else if (cmd.read_pv && nx_ok_ff && !hdr.used) begin
         // merge the free next chunk and its header
         sacc_ff <= sacc_ff + IW'(hdr.size) + IW'(1);
      end
      if (cmd.set_status) begin
         res_code_ff <= cmd.code;
         res_off_ff  <= (cmd.code == bfha_pkg::ST_OK && !action_ff) ? alloc_off : '0;
      end
      if (cmd.emit) begin
         rsp_code_ff <= res_code_ff;
         rsp_off_ff  <= res_off_ff;
      end
   end

   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_status         = rsp_code_ff;

endmodule

/* hdl/best_fit_heap_allocator_core.sv */
// channel   modport  payload                                    direction
// req_chan  sink     action, request_bytes, free_offset         in
// rsp_chan  source   payload_offset, status                     out
//
// a request is loaded and checked; one that passes walks the chunk headers
// and then updates them. chunks span at least two granules, so at most 256
// headers are walked.
// reset needs no clearing pass: only the first header is forced by a flag.
// a finished result waits in the output register while the next request
// is taken; a second result waits in the sequencer until that drains.
module best_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   bfha_req_if.sink    req_chan,
   bfha_rsp_if.source  rsp_chan
);

   bfha_pkg::cmd_type  cmd;
   bfha_pkg::stat_type stat;

   bfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfha_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_chan.action),
      .req_bytes          (req_chan.request_bytes),
      .req_offset         (req_chan.free_offset),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_payload_offset (rsp_chan.payload_offset),
      .rsp_status         (rsp_chan.status)
   );

endmodule

/* hdl/bfha_checker.sv */
module bfha_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bfha_pkg::OFF_W-1:0]   payload_offset,
   input logic [2:0]                   status
);

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_offset) && $stable(status))
      else $error("stalled result changed");

   a_err_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != bfha_pkg::ST_OK |-> payload_offset == '0)
      else $error("error result carries an offset");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> payload_offset[bfha_pkg::GSHIFT-1:0] == '0)
      else $error("payload offset not granule aligned");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .payload_offset (rsp_chan.payload_offset),
   .status         (rsp_chan.status)
);
